@@ hdl/bds_pkg.sv @@
// ----------------------------------------------------------------------------
// bds_pkg
// Field widths and fixed constants of the baud divisor search.
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam int BAUD_W  = 25;
  localparam int CLK_W   = 27;
  localparam int OSR_W   = 6;
  localparam int SBR_W   = 13;
  localparam int OSR_MIN = 4;
  localparam int EDGE_OSR_MAX = 8;

  // baud*osr fits in 31 bits, the doubled divisor in 32
  localparam int BO_W = 31;
  localparam int NW   = 32;

  localparam logic [CLK_W-1:0] CLOCK_RESET = 27'd24000000;

  // register indexes
  localparam logic REG_CLOCK_HZ = 1'b0;

endpackage

@@ hdl/bds_req_if.sv @@
// ----------------------------------------------------------------------------
// bds_req_if
// Request channel: one requested baud rate per item.
// ----------------------------------------------------------------------------
interface bds_req_if;
  logic        valid;
  logic        ready;
  logic [24:0] baud;

  modport source (output valid, output baud, input ready);
  modport sink   (input valid, input baud, output ready);
endinterface

@@ hdl/bds_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bds_rsp_if
// Result channel: chosen ratio, divisor and both-edge flag.
// ----------------------------------------------------------------------------
interface bds_rsp_if;
  logic        valid;
  logic        ready;
  logic [5:0]  osr;
  logic [12:0] sbr;
  logic        both_edge;

  modport source (output valid, output osr, output sbr, output both_edge, input ready);
  modport sink   (input valid, input osr, input sbr, input both_edge, output ready);
endinterface

@@ hdl/bds_div_cell.sv @@
// ----------------------------------------------------------------------------
// bds_div_cell
// One restoring-division step for one ratio lane. The top step only
// detects a quotient too large for the divisor field.
// ----------------------------------------------------------------------------
module bds_div_cell #(
  parameter int QW = 13,
  parameter int SH = 0
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [bds_pkg::NW+QW-1:0]  r_in,
  input  logic [bds_pkg::NW-1:0]     d_in,
  input  logic [QW-1:0]              q_in,
  input  logic                       sat_in,
  output logic [bds_pkg::NW+QW-1:0]  r_out,
  output logic [bds_pkg::NW-1:0]     d_out,
  output logic [QW-1:0]              q_out,
  output logic                       sat_out
);
  import bds_pkg::*;

  localparam int DW = NW + QW;

  logic [DW-1:0] dsh;
  logic          ge;

  assign dsh = DW'(d_in) << SH;
  assign ge  = (r_in >= dsh);

  generate
    if (SH == QW) begin : g_top
      always_ff @(posedge clk) begin
        if (en) begin
          r_out   <= r_in;
          d_out   <= d_in;
          q_out   <= q_in;
          sat_out <= sat_in | ge;
        end
      end
    end else begin : g_bit
      logic [QW-1:0] q_bit;
      assign q_bit = QW'(1) << SH;

      always_ff @(posedge clk) begin
        if (en) begin
          d_out   <= d_in;
          sat_out <= sat_in;
          r_out   <= (ge && !sat_in) ? (r_in - dsh) : r_in;
          q_out   <= (ge && !sat_in) ? (q_in | q_bit) : q_in;
        end
      end
    end
  endgenerate

endmodule

@@ hdl/bds_err_cell.sv @@
// ----------------------------------------------------------------------------
// bds_err_cell
// Clamps one lane's divisor, forms sbr*osr*baud, then its distance to clock.
// ----------------------------------------------------------------------------
module bds_err_cell #(
  parameter int QW      = 13,
  parameter int SBR_MAX = 8191
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [bds_pkg::NW-1:0]    d_in,
  input  logic [QW-1:0]             q_in,
  input  logic                      sat_in,
  input  logic [bds_pkg::CLK_W-1:0] clock_hz,
  output logic [QW+bds_pkg::BO_W-1:0] err_out,
  output logic [QW-1:0]             sbr_out
);
  import bds_pkg::*;

  localparam int EW = QW + BO_W;
  localparam logic [QW-1:0] SMAX = QW'(SBR_MAX);

  logic [QW-1:0] sbr_c;
  logic [QW-1:0] sbr_r;
  logic [EW-1:0] prod;

  always_comb begin
    if (sat_in || q_in > SMAX) begin
      sbr_c = SMAX;
    end else if (q_in == '0) begin
      sbr_c = QW'(1);
    end else begin
      sbr_c = q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbr_r   <= sbr_c;
      prod    <= EW'(sbr_c) * EW'(d_in[NW-1:1]);
      sbr_out <= sbr_r;
      err_out <= (prod > EW'(clock_hz)) ? (prod - EW'(clock_hz)) : (EW'(clock_hz) - prod);
    end
  end

endmodule

@@ hdl/bds_pick_cell.sv @@
// ----------------------------------------------------------------------------
// bds_pick_cell
// One link of the selection chain: lane K replaces the running best on a
// smaller or equal error, then everything moves to the next link.
// ----------------------------------------------------------------------------
module bds_pick_cell #(
  parameter int QW = 13,
  parameter int L  = 29,
  parameter int K  = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [QW+bds_pkg::BO_W-1:0] err_in [L],
  input  logic [QW-1:0]               sbr_in [L],
  input  logic [QW+bds_pkg::BO_W-1:0] best_err_in,
  input  logic [QW-1:0]               best_sbr_in,
  input  logic [bds_pkg::OSR_W-1:0]   best_osr_in,
  output logic [QW+bds_pkg::BO_W-1:0] err_out [L],
  output logic [QW-1:0]               sbr_out [L],
  output logic [QW+bds_pkg::BO_W-1:0] best_err_out,
  output logic [QW-1:0]               best_sbr_out,
  output logic [bds_pkg::OSR_W-1:0]   best_osr_out
);
  import bds_pkg::*;

  localparam logic [OSR_W-1:0] MY_OSR = OSR_W'(OSR_MIN + K);

  logic take;
  assign take = (err_in[K] <= best_err_in);

  always_ff @(posedge clk) begin
    if (en) begin
      err_out      <= err_in;
      sbr_out      <= sbr_in;
      best_err_out <= take ? err_in[K] : best_err_in;
      best_sbr_out <= take ? sbr_in[K] : best_sbr_in;
      best_osr_out <= take ? MY_OSR : best_osr_in;
    end
  end

endmodule

@@ hdl/uart_baud_divisor_search_top.sv @@
// ----------------------------------------------------------------------------
// uart_baud_divisor_search_top
// Best oversampling ratio and baud divisor for a requested baud rate.
// ----------------------------------------------------------------------------
//  channel | dir | payload                 | accepted when
//  req     | in  | baud[24:0]              | req.valid && req.ready
//  rsp     | out | osr[5:0] sbr[12:0] edge | rsp.valid && rsp.ready
//  apb     | in  | clock_hz at 0x0         | psel && penable && pwrite
//
//  One request per cycle sustained while the result is not stalled. The pipe
//  has an input stage, QW+1 division steps (QW = divisor bits), two error
//  stages and one selection link per ratio (L = OSR_MAX-3).
//  The whole pipe advances together; it holds while the result waits.
//  rst (synchronous) clears the stage valid bits and loads clock_hz.
// ----------------------------------------------------------------------------
module uart_baud_divisor_search_top #(
  parameter int SBR_MAX = 8191,
  parameter int OSR_MAX = 32
) (
  input  logic         clk,
  input  logic         rst,
  bds_req_if.sink      req,
  bds_rsp_if.source    rsp,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import bds_pkg::*;

  localparam int QW = $clog2(SBR_MAX + 1);
  localparam int DW = NW + QW;
  localparam int EW = QW + BO_W;
  localparam int L  = OSR_MAX - OSR_MIN + 1;
  localparam int S  = 1 + (QW + 1) + 2 + L;

  // ---------------- configuration ----------------
  logic [CLK_W-1:0] clock_hz;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CLOCK_HZ) ? 32'(clock_hz) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CLOCK_HZ) begin
      clock_hz <= pwdata[CLK_W-1:0];
    end
  end

  // ---------------- pipe control ----------------
  // single enable for every stage; a stalled result freezes the chain
  logic         en;
  logic [S-1:0] v;

  assign en        = rsp.ready || !v[S-1];
  assign req.ready = en;
  assign rsp.valid = v[S-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[S-2:0], req.valid};
    end
  end

  // ---------------- input stage: numerator / denominator per lane ----------------
  // sbr = floor((2C + bo) / (2bo)), bo = baud*osr
  logic [DW-1:0] dr   [QW+2][L];
  logic [NW-1:0] dd   [QW+2][L];
  logic [QW-1:0] dq   [QW+2][L];
  logic          dsat [QW+2][L];

  logic [EW-1:0] le [L+1][L];
  logic [QW-1:0] ls [L+1][L];
  logic [EW-1:0] be [L+1];
  logic [QW-1:0] bs [L+1];
  logic [OSR_W-1:0] bo_osr [L+1];

  genvar gl, gs;
  generate
    for (gl = 0; gl < L; gl++) begin : g_lane
      logic [BO_W-1:0] bo;
      assign bo = BO_W'(req.baud) * BO_W'(OSR_MIN + gl);

      always_ff @(posedge clk) begin
        if (en) begin
          dr[0][gl]   <= DW'({clock_hz, 1'b0}) + DW'(bo);
          dd[0][gl]   <= {bo, 1'b0};
          dq[0][gl]   <= '0;
          dsat[0][gl] <= 1'b0;
        end
      end

      // division steps, saturation check first
      for (gs = 0; gs <= QW; gs++) begin : g_step
        bds_div_cell #(.QW(QW), .SH(QW - gs)) u_div (
          .clk     (clk),
          .en      (en),
          .r_in    (dr[gs][gl]),
          .d_in    (dd[gs][gl]),
          .q_in    (dq[gs][gl]),
          .sat_in  (dsat[gs][gl]),
          .r_out   (dr[gs+1][gl]),
          .d_out   (dd[gs+1][gl]),
          .q_out   (dq[gs+1][gl]),
          .sat_out (dsat[gs+1][gl])
        );
      end

      bds_err_cell #(.QW(QW), .SBR_MAX(SBR_MAX)) u_err (
        .clk      (clk),
        .en       (en),
        .d_in     (dd[QW+1][gl]),
        .q_in     (dq[QW+1][gl]),
        .sat_in   (dsat[QW+1][gl]),
        .clock_hz (clock_hz),
        .err_out  (le[0][gl]),
        .sbr_out  (ls[0][gl])
      );
    end

    // ---------------- selection chain, ratios upward ----------------
    assign be[0]     = '1;
    assign bs[0]     = QW'(1);
    assign bo_osr[0] = OSR_W'(OSR_MIN);

    for (gl = 0; gl < L; gl++) begin : g_pick
      bds_pick_cell #(.QW(QW), .L(L), .K(gl)) u_pick (
        .clk          (clk),
        .en           (en),
        .err_in       (le[gl]),
        .sbr_in       (ls[gl]),
        .best_err_in  (be[gl]),
        .best_sbr_in  (bs[gl]),
        .best_osr_in  (bo_osr[gl]),
        .err_out      (le[gl+1]),
        .sbr_out      (ls[gl+1]),
        .best_err_out (be[gl+1]),
        .best_sbr_out (bs[gl+1]),
        .best_osr_out (bo_osr[gl+1])
      );
    end
  endgenerate

  assign rsp.osr       = bo_osr[L];
  assign rsp.sbr       = SBR_W'(bs[L]);
  assign rsp.both_edge = (bo_osr[L] <= OSR_W'(EDGE_OSR_MAX));

  // ---------------- checks ----------------
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.osr) && $stable(rsp.sbr))
    else $error("result changed while stalled");

  a_osr_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.osr >= OSR_W'(OSR_MIN) && rsp.osr <= OSR_W'(OSR_MAX))
    else $error("ratio out of range");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !rsp.valid |-> req.ready)
    else $error("input blocked with empty output");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    req.ready && !req.valid |=> !v[0])
    else $error("stage valid without request");

endmodule

@@ dv/uart_baud_divisor_search_top_test.sv @@
// ----------------------------------------------------------------------------
// uart_baud_divisor_search_top_test
// Self-checking bench for the baud divisor search: drives baud requests
// under random idling, predicts ratio/divisor/edge flag, and steps the
// clock register through several values including its extremes.
// ----------------------------------------------------------------------------
module uart_baud_divisor_search_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bds_pkg::*;

  localparam int SBR_LIM = 8191;
  localparam int OSR_LIM = 32;
  // pipe depth: input + 14 division steps + 2 error + 29 select, with margin
  localparam int DRAIN   = 80;
  localparam int WD_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bds_req_if req();
  bds_rsp_if rsp();

  uart_baud_divisor_search_top uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [OSR_W-1:0] osr;
    logic [SBR_W-1:0] sbr;
    logic             both_edge;
  } divisor_t;

  // predictor's own copy of the clock register
  logic [CLK_W-1:0] clk_hz_shadow;
  divisor_t         pending_q[$];
  int               fails = 0;
  int               sent = 0;
  int               seen = 0;
  int               idle_cycles = 0;
  bit               quiet = 1'b0;   // no idling in the closing stretch
  bit               done = 1'b0;

  // Scan ratios upward; a later ratio replaces the best one on a tie.
  function automatic divisor_t best_divisor(logic [BAUD_W-1:0] baud,
                                            logic [CLK_W-1:0] hz);
    divisor_t   r;
    logic [63:0] bo, sbr, err, prod, best_err;
    logic [63:0] best_sbr, best_osr;
    best_err = '1;
    best_sbr = 1;
    best_osr = OSR_MIN;
    for (int o = OSR_MIN; o <= OSR_LIM; o++) begin
      if (baud == 0) begin
        sbr = SBR_LIM;
      end else begin
        bo  = 64'(baud) * 64'(o);
        sbr = (2 * 64'(hz) + bo) / (2 * bo);
        if (sbr < 1) sbr = 1;
        else if (sbr > SBR_LIM) sbr = SBR_LIM;
      end
      prod = sbr * 64'(o) * 64'(baud);
      err  = (prod > 64'(hz)) ? prod - 64'(hz) : 64'(hz) - prod;
      if (err <= best_err) begin
        best_err = err;
        best_sbr = sbr;
        best_osr = o;
      end
    end
    r.osr       = best_osr[OSR_W-1:0];
    r.sbr       = best_sbr[SBR_W-1:0];
    r.both_edge = (best_osr <= EDGE_OSR_MAX);
    return r;
  endfunction

  // ---- result side: random stalls, compare against oldest expectation ----
  initial begin
    int stall;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9);
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        // stretch with no stalls
        rsp.ready <= 1'b1;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    divisor_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      seen++;
      if (pending_q.size() == 0) begin
        $error("result with no request pending: osr=%0d sbr=%0d", rsp.osr, rsp.sbr);
        fails++;
      end else begin
        want = pending_q.pop_front();
        if (rsp.osr !== want.osr) begin
          $error("osr: expected %0d, got %0d", want.osr, rsp.osr);
          fails++;
        end
        if (rsp.sbr !== want.sbr) begin
          $error("sbr: expected %0d, got %0d", want.sbr, rsp.sbr);
          fails++;
        end
        if (rsp.both_edge !== want.both_edge) begin
          $error("both_edge: expected %0b, got %0b", want.both_edge, rsp.both_edge);
          fails++;
        end
      end
    end
  end

  // ---- watchdog: cycles with no request or result accepted and no APB access ----
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT && !done) begin
      $display("watchdog: no progress for %0d cycles", WD_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // ---- APB write: setup then access, only while idle ----
  task automatic write_clock_hz(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CLOCK_HZ, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    clk_hz_shadow = value[CLK_W-1:0];
  endtask

  // wait until every pending result is back, then let the pipe empty
  task automatic drain_results();
    while (pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  // Send one request. Expectation is queued at the accepting edge so the
  // result checker never sees a result ahead of its expectation.
  task automatic send_baud(logic [BAUD_W-1:0] baud, bit gaps);
    if (gaps && !quiet && $urandom_range(0, 6) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.baud  <= baud;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_q.push_back(best_divisor(baud, clk_hz_shadow));
    sent++;
    @(negedge clk);
  endtask

  // random baud: common UART rates in four of ten picks, otherwise small or wide random values
  function automatic logic [BAUD_W-1:0] pick_baud();
    int unsigned common[10] = '{300, 1200, 9600, 19200, 38400, 57600,
                                115200, 230400, 921600, 3000000};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return BAUD_W'(common[$urandom_range(0, 9)] + $urandom_range(0, 3) - 1);
      4:          return BAUD_W'($urandom_range(0, 63));
      5:          return BAUD_W'($urandom);
      default:    return BAUD_W'($urandom_range(1, 25000000));
    endcase
  endfunction

  // directed rows: baud, and a typed-in expectation where obvious
  typedef struct {
    logic [BAUD_W-1:0] baud;
    bit               known;
    divisor_t         want;
  } stim_row_t;

  stim_row_t directed[] = '{
    // zero baud saturates: every error equals clock, tie goes to top ratio
    '{25'd0,        1'b1, '{6'd32, 13'd8191, 1'b0}},
    '{25'd1,        1'b0, '{'0, '0, 1'b0}},
    '{25'd9600,     1'b0, '{'0, '0, 1'b0}},
    '{25'd115200,   1'b0, '{'0, '0, 1'b0}},
    '{25'd3000000,  1'b0, '{'0, '0, 1'b0}},
    // 24 MHz / 6 Mbaud: exact at osr 4, sbr 1
    '{25'd6000000,  1'b1, '{6'd4, 13'd1, 1'b1}},
    // baud above clock/4: divisor clamps to 1, smallest ratio is closest
    '{25'd25000000, 1'b1, '{6'd4, 13'd1, 1'b1}},
    '{25'h1FFFFFF,  1'b1, '{6'd4, 13'd1, 1'b1}},
    '{25'h0AAAAAA,  1'b0, '{'0, '0, 1'b0}},
    '{25'h1555555,  1'b0, '{'0, '0, 1'b0}},
    '{25'd50,       1'b0, '{'0, '0, 1'b0}}
  };

  logic [31:0] clock_set[6] = '{32'd1000000, 32'd100000000, 32'd48000000,
                                32'h7FFFFFF, 32'd0, 32'd24000000};

  initial begin
    int n;
    divisor_t calc;
    req.valid = 1'b0;
    req.baud  = '0;
    clk_hz_shadow = CLOCK_RESET;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows at the reset clock
    foreach (directed[i]) begin
      calc = best_divisor(directed[i].baud, clk_hz_shadow);
      if (directed[i].known && calc !== directed[i].want) begin
        $error("table row %0d: osr/sbr/edge expected %h, predictor %h",
               i, directed[i].want, calc);
        fails++;
      end
      send_baud(directed[i].baud, 1'b0);
    end
    req.valid <= 1'b0;

    // sweep clock settings; each phase gets a share of random requests
    foreach (clock_set[k]) begin
      drain_results();
      write_clock_hz(clock_set[k]);
      n = (k == 4) ? 40 : 160;
      for (int j = 0; j < n; j++) begin
        if (k == 5 && j == 70) begin
          // sender holds off until the result side is empty
          req.valid <= 1'b0;
          while (pending_q.size() != 0) @(negedge clk);
        end
        if (k == 5 && j == 100) quiet = 1'b1;
        send_baud(pick_baud(), 1'b1);
      end
      req.valid <= 1'b0;
    end

    while (pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    done = 1'b1;
    $display("sent %0d baud requests over %0d clock settings, %0d results checked",
             sent, 7, seen);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
